/* rtl/core/dpss_pkg.sv */
// Package: shared types, constants, saturation and microcode program of the PLL sample step.
package dpss_pkg;

    // Datapath widths
    localparam int MUL_W  = 33;
    localparam int PROD_W = 2 * MUL_W;
    localparam int ACC_W  = 40;
    localparam int UPC_W  = 5;
    localparam int SINE_W = 18;

    // Configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] REG_NOMINAL_STEP   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MONITOR_SELECT = 2'd1;
    localparam logic [15:0] NOMINAL_STEP_RST = 16'd3277;

    // Monitor select codes (the unused code reads as the clamped sine)
    localparam logic [1:0] MON_PHASE   = 2'd0;
    localparam logic [1:0] MON_RAW     = 2'd1;
    localparam logic [1:0] MON_CLAMPED = 2'd2;

    // Loop coefficients, Q16
    localparam logic signed [MUL_W-1:0] K_LPF_IN  = 33'sd2746;
    localparam logic signed [MUL_W-1:0] K_LPF_OUT = 33'sd64160;
    localparam logic signed [MUL_W-1:0] K_COMP_E  = 33'sd1931346;
    localparam logic signed [MUL_W-1:0] K_COMP_EP = 33'sd1927283;
    localparam logic signed [MUL_W-1:0] K_DT      = 33'sd66;
    localparam logic signed [MUL_W-1:0] K_INV_2PI = 33'sd10430;
    localparam logic signed [MUL_W-1:0] K_2PI     = 33'sd411775;

    localparam logic signed [PROD_W-1:0] ROUND_Q16 = 66'sd32768;
    localparam logic signed [SINE_W-1:0] HALF_Q16  = 18'sd32768;

    // Sine polynomial coefficients, Q30
    localparam logic [30:0] P_C1 = 31'd1686629713;
    localparam logic [30:0] P_C3 = 31'd693598669;
    localparam logic [30:0] P_C5 = 31'd85569306;
    localparam logic [30:0] P_C7 = 31'd5026994;
    localparam logic [30:0] P_C9 = 31'd172272;
    localparam logic [1:0]  HORNER_LAST = 2'd3;

    // Program addresses
    localparam logic [UPC_W-1:0] UPC_IDLE   = 5'd0;
    localparam logic [UPC_W-1:0] UPC_HORNER = 5'd19;

    typedef enum logic [1:0] {
        SEQ_NEXT,
        SEQ_WAIT_IN,
        SEQ_LOOP,
        SEQ_END
    } seq_op_t;

    typedef enum logic [3:0] {
        MA_X,
        MA_FIN,
        MA_FOUT,
        MA_CERR,
        MA_COUT,
        MA_RAD,
        MA_SX,
        MA_SX2,
        MA_PHASE
    } mul_a_t;

    typedef enum logic [3:0] {
        MB_SINE,
        MB_LPF_IN,
        MB_LPF_OUT,
        MB_COMP_E,
        MB_COMP_EP,
        MB_DT,
        MB_INV_2PI,
        MB_2PI,
        MB_SX,
        MB_SP
    } mul_b_t;

    typedef enum logic [2:0] {
        ACC_HOLD,
        ACC_LDQ,
        ACC_ADDQ,
        ACC_SUBQ,
        ACC_NEG,
        ACC_LD_COUT,
        ACC_LDQ_NOM
    } acc_op_t;

    typedef enum logic [3:0] {
        WR_NONE,
        WR_FIN,
        WR_FOUT,
        WR_CERR,
        WR_COUT,
        WR_RAD,
        WR_PHASE,
        WR_SX,
        WR_SX2,
        WR_SP,
        WR_SINE,
        WR_OUT
    } wr_t;

    typedef struct packed {
        seq_op_t          seq;
        logic [UPC_W-1:0] target;
        logic             mul_en;
        mul_a_t           mul_a;
        mul_b_t           mul_b;
        acc_op_t          acc;
        wr_t              wr;
    } ctl_word_t;

    // Clip a wide accumulator to signed 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
        logic fits;
        fits = (v[ACC_W-1:31] == {(ACC_W-31){1'b0}}) || (v[ACC_W-1:31] == {(ACC_W-31){1'b1}});
        if (fits)
            return v[31:0];
        else
            return {v[ACC_W-1], {31{~v[ACC_W-1]}}};
    endfunction

    // Horner coefficient for pass k, highest order first after C9
    function automatic logic [30:0] horner_coef(input logic [1:0] k);
        case (k)
            2'd0:    return P_C7;
            2'd1:    return P_C5;
            2'd2:    return P_C3;
            default: return P_C1;
        endcase
    endfunction

    // Microcode ROM: one control word per step
    function automatic ctl_word_t ucode(input logic [UPC_W-1:0] upc);
        case (upc)
            // wait for a sample
            5'd0:  return '{SEQ_WAIT_IN, UPC_IDLE, 1'b0, MA_X,     MB_SINE,    ACC_HOLD,    WR_NONE};
            // phase detector product
            5'd1:  return '{SEQ_NEXT,    UPC_IDLE, 1'b1, MA_X,     MB_SINE,    ACC_HOLD,    WR_NONE};
            // low-pass filter
            5'd2:  return '{SEQ_NEXT,    UPC_IDLE, 1'b1, MA_FIN,   MB_LPF_IN,  ACC_LDQ,     WR_NONE};
            5'd3:  return '{SEQ_NEXT,    UPC_IDLE, 1'b1, MA_FOUT,  MB_LPF_OUT, ACC_LDQ,     WR_FIN};
            5'd4:  return '{SEQ_NEXT,    UPC_IDLE, 1'b0, MA_X,     MB_SINE,    ACC_ADDQ,    WR_NONE};
            5'd5:  return '{SEQ_NEXT,    UPC_IDLE, 1'b0, MA_X,     MB_SINE,    ACC_NEG,     WR_FOUT};
            // lead-lag compensator
            5'd6:  return '{SEQ_NEXT,    UPC_IDLE, 1'b1, MA_CERR,  MB_COMP_EP, ACC_LD_COUT, WR_CERR};
            5'd7:  return '{SEQ_NEXT,    UPC_IDLE, 1'b1, MA_CERR,  MB_COMP_E,  ACC_SUBQ,    WR_NONE};
            5'd8:  return '{SEQ_NEXT,    UPC_IDLE, 1'b0, MA_X,     MB_SINE,    ACC_ADDQ,    WR_NONE};
            5'd9:  return '{SEQ_NEXT,    UPC_IDLE, 1'b0, MA_X,     MB_SINE,    ACC_HOLD,    WR_COUT};
            // phase increment
            5'd10: return '{SEQ_NEXT,    UPC_IDLE, 1'b1, MA_COUT,  MB_DT,      ACC_HOLD,    WR_NONE};
            5'd11: return '{SEQ_NEXT,    UPC_IDLE, 1'b0, MA_X,     MB_SINE,    ACC_LDQ,     WR_NONE};
            5'd12: return '{SEQ_NEXT,    UPC_IDLE, 1'b0, MA_X,     MB_SINE,    ACC_HOLD,    WR_RAD};
            5'd13: return '{SEQ_NEXT,    UPC_IDLE, 1'b1, MA_RAD,   MB_INV_2PI, ACC_HOLD,    WR_NONE};
            5'd14: return '{SEQ_NEXT,    UPC_IDLE, 1'b0, MA_X,     MB_SINE,    ACC_LDQ_NOM, WR_NONE};
            5'd15: return '{SEQ_NEXT,    UPC_IDLE, 1'b0, MA_X,     MB_SINE,    ACC_HOLD,    WR_PHASE};
            // sine of the new phase
            5'd16: return '{SEQ_NEXT,    UPC_IDLE, 1'b0, MA_X,     MB_SINE,    ACC_HOLD,    WR_SX};
            5'd17: return '{SEQ_NEXT,    UPC_IDLE, 1'b1, MA_SX,    MB_SX,      ACC_HOLD,    WR_NONE};
            5'd18: return '{SEQ_NEXT,    UPC_IDLE, 1'b0, MA_X,     MB_SINE,    ACC_HOLD,    WR_SX2};
            5'd19: return '{SEQ_NEXT,    UPC_IDLE, 1'b1, MA_SX2,   MB_SP,      ACC_HOLD,    WR_NONE};
            5'd20: return '{SEQ_LOOP,  UPC_HORNER, 1'b0, MA_X,     MB_SINE,    ACC_HOLD,    WR_SP};
            5'd21: return '{SEQ_NEXT,    UPC_IDLE, 1'b1, MA_SX,    MB_SP,      ACC_HOLD,    WR_NONE};
            5'd22: return '{SEQ_NEXT,    UPC_IDLE, 1'b1, MA_PHASE, MB_2PI,     ACC_HOLD,    WR_SINE};
            // hand over the result
            5'd23: return '{SEQ_END,     UPC_IDLE, 1'b0, MA_X,     MB_SINE,    ACC_HOLD,    WR_OUT};
            default: return '{SEQ_END,   UPC_IDLE, 1'b0, MA_X,     MB_SINE,    ACC_HOLD,    WR_NONE};
        endcase
    endfunction

endpackage

/* rtl/core/dpss_if.sv */
// Stream interfaces: sample requests in, loop result requests out.

interface dpss_in_if #(
    parameter int SAMPLE_BITS = 12
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] adc_code;

    modport source (output valid, output adc_code, input ready);
    modport sink   (input valid, input adc_code, output ready);
endinterface

interface dpss_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] loop_error;
    logic signed [17:0] sine_out;
    logic signed [31:0] monitor_out;
    logic               clamped;

    modport source (output valid, output loop_error, output sine_out, output monitor_out,
                    output clamped, input ready);
    modport sink   (input valid, input loop_error, input sine_out, input monitor_out,
                    input clamped, output ready);
endinterface

/* rtl/core/digital_pll_sample_step.sv */
// Top level: all-digital PLL sample step run by a microcoded sequencer over one multiplier.
//
//   channel     dir  payload                                          handshake
//   sample_ch   in   adc_code                                         valid/ready
//   result_ch   out  loop_error, sine_out, monitor_out, clamped       valid/ready
//   cfg         in   cfg_index, cfg_data                              cfg_we
//
// One sample runs from acceptance to the next ready through 24 program steps, with
// the Horner pass of the sine run four times, all through the single 33x33 multiplier.
// The result sits in an output register; a new sample is taken while it waits, and the
// sequencer only stalls on its last step if the previous result is still held.
// Reset clears the loop state, the phase, the stored sine and the program counter.

module digital_pll_sample_step #(
    parameter int SINE_ADDR_BITS = 10,
    parameter int PHASE_BITS     = 16,
    parameter int SAMPLE_BITS    = 12
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [dpss_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [dpss_pkg::CFG_DATA_W-1:0]    cfg_data,
    dpss_in_if.sink                            sample_ch,
    dpss_out_if.source                         result_ch
);
    import dpss_pkg::*;

    localparam int QB   = SINE_ADDR_BITS - 2;
    localparam int XPAD = 30 - QB;
    localparam int SPAD = 17 - SAMPLE_BITS;

    // Control
    logic [UPC_W-1:0] upc_reg, upc_next;
    logic [1:0]       k_reg, k_next;
    ctl_word_t        ctl;
    logic             step_go;
    logic             out_free;

    // Configuration registers
    logic [15:0] nominal_step_reg, nominal_step_next;
    logic [1:0]  monitor_select_reg, monitor_select_next;

    // Loop state
    logic signed [31:0]        fin_reg, fin_next;
    logic signed [31:0]        fout_reg, fout_next;
    logic signed [31:0]        cerr_reg, cerr_next;
    logic signed [31:0]        cout_reg, cout_next;
    logic [PHASE_BITS-1:0]     phase_reg, phase_next;
    logic signed [SINE_W-1:0]  sine_reg, sine_next;

    // Working registers
    logic signed [17:0]        x_reg, x_next;
    logic signed [31:0]        rad_reg, rad_next;
    logic [30:0]               sx_reg, sx_next;
    logic [30:0]               sx2_reg, sx2_next;
    logic [30:0]               sp_reg, sp_next;
    logic                      sneg_reg, sneg_next;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;
    logic signed [PROD_W-1:0]  prod_reg, prod_next;

    // Output register
    logic                      out_valid_reg, out_valid_next;
    logic signed [31:0]        loop_error_reg, loop_error_next;
    logic signed [SINE_W-1:0]  sine_out_reg, sine_out_next;
    logic signed [31:0]        monitor_out_reg, monitor_out_next;
    logic                      clamped_reg, clamped_next;

    // Datapath nets
    logic signed [MUL_W-1:0]   mul_a_val, mul_b_val;
    logic signed [PROD_W-1:0]  prod_rnd, q_wide;
    logic signed [ACC_W-1:0]   qv;
    logic signed [31:0]        sat_acc;
    logic [32:0]               s30;
    logic [PHASE_BITS+15:0]    delta_wide;
    logic [PHASE_BITS-1:0]     delta;
    logic [PHASE_BITS+SINE_ADDR_BITS-1:0] addr_wide;
    logic [SINE_ADDR_BITS-1:0] sine_addr;
    logic [1:0]                quad;
    logic [QB:0]               sine_n;
    logic [32:0]               sine_rnd;
    logic [18:0]               sine_mag_wide;
    logic [16:0]               sine_mag;
    logic signed [SINE_W-1:0]  sine_new;
    logic [PROD_W-1:0]         mon_wide;
    logic signed [SINE_W-1:0]  sine_sat;
    logic                      clip;

    // Program word and step handshake
    assign ctl      = ucode(upc_reg);
    assign out_free = !out_valid_reg || result_ch.ready;

    always_comb
    begin
        case (ctl.seq)
            SEQ_WAIT_IN: step_go = sample_ch.valid;
            SEQ_END:     step_go = out_free;
            default:     step_go = 1'b1;
        endcase
    end

    assign sample_ch.ready = (ctl.seq == SEQ_WAIT_IN);

    // Sequencer
    always_comb
    begin
        upc_next = upc_reg;
        k_next   = k_reg;
        case (ctl.seq)
            SEQ_WAIT_IN:
            begin
                if (step_go)
                    upc_next = upc_reg + UPC_W'(1);
            end
            SEQ_LOOP:
            begin
                k_next = k_reg + 2'd1;
                if (k_reg != HORNER_LAST)
                    upc_next = ctl.target;
                else
                    upc_next = upc_reg + UPC_W'(1);
            end
            SEQ_END:
            begin
                if (step_go)
                    upc_next = UPC_IDLE;
            end
            default: upc_next = upc_reg + UPC_W'(1);
        endcase
        if (ctl.wr == WR_SX2)
            k_next = 2'd0;
    end

    // Shared multiplier operands
    always_comb
    begin
        case (ctl.mul_a)
            MA_X:     mul_a_val = MUL_W'(x_reg);
            MA_FIN:   mul_a_val = MUL_W'(fin_reg);
            MA_FOUT:  mul_a_val = MUL_W'(fout_reg);
            MA_CERR:  mul_a_val = MUL_W'(cerr_reg);
            MA_COUT:  mul_a_val = MUL_W'(cout_reg);
            MA_RAD:   mul_a_val = MUL_W'(rad_reg);
            MA_SX:    mul_a_val = $signed({2'b00, sx_reg});
            MA_SX2:   mul_a_val = $signed({2'b00, sx2_reg});
            MA_PHASE: mul_a_val = $signed(MUL_W'(phase_reg));
            default:  mul_a_val = '0;
        endcase
        case (ctl.mul_b)
            MB_SINE:    mul_b_val = MUL_W'(sine_reg);
            MB_LPF_IN:  mul_b_val = K_LPF_IN;
            MB_LPF_OUT: mul_b_val = K_LPF_OUT;
            MB_COMP_E:  mul_b_val = K_COMP_E;
            MB_COMP_EP: mul_b_val = K_COMP_EP;
            MB_DT:      mul_b_val = K_DT;
            MB_INV_2PI: mul_b_val = K_INV_2PI;
            MB_2PI:     mul_b_val = K_2PI;
            MB_SX:      mul_b_val = $signed({2'b00, sx_reg});
            MB_SP:      mul_b_val = $signed({2'b00, sp_reg});
            default:    mul_b_val = '0;
        endcase
    end

    // Product post-processing: Q16 round half up, Q30 truncation, saturation
    assign prod_rnd = prod_reg + ROUND_Q16;
    assign q_wide   = prod_rnd >>> 16;
    assign qv       = q_wide[ACC_W-1:0];
    assign s30      = prod_reg[62:30];
    assign sat_acc  = sat32(acc_reg);

    // Phase increment aligned to the phase width
    assign delta_wide = {acc_reg[15:0], {PHASE_BITS{1'b0}}};
    assign delta      = delta_wide[PHASE_BITS+15:16];

    // Sine argument from the phase: quadrant fold
    assign addr_wide = {phase_reg, {SINE_ADDR_BITS{1'b0}}};
    assign sine_addr = addr_wide[PHASE_BITS+SINE_ADDR_BITS-1:PHASE_BITS];
    assign quad      = sine_addr[SINE_ADDR_BITS-1:SINE_ADDR_BITS-2];
    assign sine_n    = quad[0] ? ((QB+1)'(1) << QB) - {1'b0, sine_addr[QB-1:0]}
                               : {1'b0, sine_addr[QB-1:0]};

    // Sine result: Q30 to Q16 with rounding, clipped at one
    assign sine_rnd      = {1'b0, prod_reg[61:30]} + 33'd8192;
    assign sine_mag_wide = sine_rnd[32:14];
    assign sine_mag      = (sine_mag_wide > 19'd65536) ? 17'd65536 : sine_mag_wide[16:0];
    assign sine_new      = sneg_reg ? -$signed({1'b0, sine_mag}) : $signed({1'b0, sine_mag});

    // Monitor terms
    assign mon_wide = prod_reg >> PHASE_BITS;
    assign clip     = (sine_reg > HALF_Q16) || (sine_reg < -HALF_Q16);
    assign sine_sat = (sine_reg > HALF_Q16) ? HALF_Q16 :
                      (sine_reg < -HALF_Q16) ? -HALF_Q16 : sine_reg;

    // Register next values
    always_comb
    begin
        nominal_step_next   = nominal_step_reg;
        monitor_select_next = monitor_select_reg;
        fin_next            = fin_reg;
        fout_next           = fout_reg;
        cerr_next           = cerr_reg;
        cout_next           = cout_reg;
        phase_next          = phase_reg;
        sine_next           = sine_reg;
        x_next              = x_reg;
        rad_next            = rad_reg;
        sx_next             = sx_reg;
        sx2_next            = sx2_reg;
        sp_next             = sp_reg;
        sneg_next           = sneg_reg;
        acc_next            = acc_reg;
        prod_next           = prod_reg;
        out_valid_next      = out_valid_reg && !result_ch.ready;
        loop_error_next     = loop_error_reg;
        sine_out_next       = sine_out_reg;
        monitor_out_next    = monitor_out_reg;
        clamped_next        = clamped_reg;

        // configuration writes
        if (cfg_we)
        begin
            case (cfg_index)
                REG_NOMINAL_STEP:   nominal_step_next = cfg_data[15:0];
                REG_MONITOR_SELECT: monitor_select_next = cfg_data[1:0];
                default: ;
            endcase
        end

        // sample capture, mapped to Q16 about zero
        if (ctl.seq == SEQ_WAIT_IN && step_go)
            x_next = $signed({1'b0, sample_ch.adc_code, {SPAD{1'b0}}}) - 18'sd65536;

        if (ctl.mul_en)
            prod_next = mul_a_val * mul_b_val;

        // accumulator
        case (ctl.acc)
            ACC_LDQ:     acc_next = qv;
            ACC_ADDQ:    acc_next = acc_reg + qv;
            ACC_SUBQ:    acc_next = acc_reg - qv;
            ACC_NEG:     acc_next = -ACC_W'(sat_acc);
            ACC_LD_COUT: acc_next = ACC_W'(cout_reg);
            ACC_LDQ_NOM: acc_next = qv + $signed(ACC_W'(nominal_step_reg));
            default:     acc_next = acc_reg;
        endcase

        // write-back
        case (ctl.wr)
            WR_FIN:   fin_next = sat_acc;
            WR_FOUT:  fout_next = sat_acc;
            WR_CERR:  cerr_next = sat_acc;
            WR_COUT:  cout_next = sat_acc;
            WR_RAD:   rad_next = sat_acc;
            WR_PHASE: phase_next = phase_reg + delta;
            WR_SX:
            begin
                sx_next   = {sine_n, {XPAD{1'b0}}};
                sneg_next = quad[1];
            end
            WR_SX2:
            begin
                sx2_next = s30[30:0];
                sp_next  = P_C9;
            end
            WR_SP:    sp_next = horner_coef(k_reg) - s30[30:0];
            WR_SINE:  sine_next = sine_new;
            WR_OUT:
            begin
                if (step_go)
                begin
                    out_valid_next  = 1'b1;
                    loop_error_next = cerr_reg;
                    sine_out_next   = sine_reg;
                    clamped_next    = clip;
                    case (monitor_select_reg)
                        MON_PHASE: monitor_out_next = mon_wide[31:0];
                        MON_RAW:   monitor_out_next = 32'(sine_reg);
                        default:   monitor_out_next = 32'(sine_sat);
                    endcase
                end
            end
            default: ;
        endcase
    end

    // Control, configuration and loop state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg            <= UPC_IDLE;
            k_reg              <= 2'd0;
            nominal_step_reg   <= NOMINAL_STEP_RST;
            monitor_select_reg <= MON_CLAMPED;
            fin_reg            <= '0;
            fout_reg           <= '0;
            cerr_reg           <= '0;
            cout_reg           <= '0;
            phase_reg          <= '0;
            sine_reg           <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            upc_reg            <= upc_next;
            k_reg              <= k_next;
            nominal_step_reg   <= nominal_step_next;
            monitor_select_reg <= monitor_select_next;
            fin_reg            <= fin_next;
            fout_reg           <= fout_next;
            cerr_reg           <= cerr_next;
            cout_reg           <= cout_next;
            phase_reg          <= phase_next;
            sine_reg           <= sine_next;
            out_valid_reg      <= out_valid_next;
        end
    end

    // Working and output payload
    always_ff @(posedge clk)
    begin
        x_reg           <= x_next;
        rad_reg         <= rad_next;
        sx_reg          <= sx_next;
        sx2_reg         <= sx2_next;
        sp_reg          <= sp_next;
        sneg_reg        <= sneg_next;
        acc_reg         <= acc_next;
        prod_reg        <= prod_next;
        loop_error_reg  <= loop_error_next;
        sine_out_reg    <= sine_out_next;
        monitor_out_reg <= monitor_out_next;
        clamped_reg     <= clamped_next;
    end

    assign result_ch.valid       = out_valid_reg;
    assign result_ch.loop_error  = loop_error_reg;
    assign result_ch.sine_out    = sine_out_reg;
    assign result_ch.monitor_out = monitor_out_reg;
    assign result_ch.clamped     = clamped_reg;

    // A sample is worked on alone: no second request straight after one is taken
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        sample_ch.valid && sample_ch.ready |=> !sample_ch.ready)
        else $error("sample taken while the previous one is in progress");

    // The result register is only loaded from the hand-over step
    a_out_from_program: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(ctl.wr == WR_OUT))
        else $error("result appeared outside the hand-over step");

    // The phase moves only on its write step
    a_phase_write: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(phase_reg) |-> $past(ctl.wr == WR_PHASE))
        else $error("phase changed outside its update step");

endmodule
